/* rtl/core/plb_pkg.sv */
// Shared constants, codes and record types of the price level order book.
package plb_pkg;

  localparam int ORDER_SLOTS = 1024;
  localparam int LEVEL_DEPTH = 64;
  localparam int PRICE_BITS  = 20;
  localparam int QTY_BITS    = 24;
  localparam int TOT_BITS    = 32;

  localparam int ORD_AW = $clog2(ORDER_SLOTS);
  localparam int LVL_AW = $clog2(LEVEL_DEPTH);
  localparam int LVL_CW = LVL_AW + 1;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_REDUCE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic                  is_bid;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } ord_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic [TOT_BITS-1:0]   qty;
  } lvl_t;

endpackage

/* rtl/core/plb_ifs.sv */
// Handshake interfaces for the order book's input and result channels.
interface plb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  slot_id;
  logic [19:0] price;
  logic [23:0] quantity;
  logic        is_bid;
  modport source (output valid, action, slot_id, price, quantity, is_bid, input ready);
  modport sink (input valid, action, slot_id, price, quantity, is_bid, output ready);
endinterface

interface plb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               bid_present;
  logic [19:0]        best_bid_price;
  logic [31:0]        best_bid_qty;
  logic               ask_present;
  logic [19:0]        best_ask_price;
  logic [31:0]        best_ask_qty;
  logic signed [20:0] spread_ticks;
  modport source (output valid, status, bid_present, best_bid_price, best_bid_qty,
                  ask_present, best_ask_price, best_ask_qty, spread_ticks, input ready);
  modport sink (input valid, status, bid_present, best_bid_price, best_bid_qty,
                ask_present, best_ask_price, best_ask_qty, spread_ticks, output ready);
endinterface

/* rtl/core/price_level_order_book.sv */
// Price level order book: after reset the order table is cleared slot by slot,
// during which no word is accepted. A word that touches the book then walks over
// one side's sorted level memory, reading and comparing one entry at a time, and
// an insert or removal also shifts each entry that moves.
// The block takes the next word only after the previous one's
// result is in the output register; that register holds until the sink takes it.
module price_level_order_book (
  input  logic            clk,
  input  logic            rst_n,
  plb_in_if.sink          in_if,
  plb_out_if.source       out_if
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ORD_WT  = 5'd2;
  localparam logic [4:0] S_ORD_CHK = 5'd3;
  localparam logic [4:0] S_SCAN_RD = 5'd4;
  localparam logic [4:0] S_SCAN_CM = 5'd5;
  localparam logic [4:0] S_DEL_RD  = 5'd6;
  localparam logic [4:0] S_DEL_WR  = 5'd7;
  localparam logic [4:0] S_INS_RD  = 5'd8;
  localparam logic [4:0] S_INS_WR  = 5'd9;
  localparam logic [4:0] S_ADD_REC = 5'd10;
  localparam logic [4:0] S_TOP_B   = 5'd11;
  localparam logic [4:0] S_TOP_A   = 5'd12;
  localparam logic [4:0] S_TOP_L   = 5'd13;
  localparam logic [4:0] S_OUT     = 5'd14;

  plb_pkg::ord_t ord_mem [plb_pkg::ORDER_SLOTS];
  plb_pkg::lvl_t lvl_mem [2*plb_pkg::LEVEL_DEPTH];

  logic [4:0]                      state_r, state_nxt;
  logic [1:0]                      act_r, act_nxt;
  logic [9:0]                      slot_r, slot_nxt;
  logic                            side_r, side_nxt;
  logic [plb_pkg::PRICE_BITS-1:0]  price_r, price_nxt;
  logic [plb_pkg::QTY_BITS-1:0]    qty_r, qty_nxt;
  logic                            in_bid_r, in_bid_nxt;
  logic [plb_pkg::PRICE_BITS-1:0]  in_price_r, in_price_nxt;
  logic [plb_pkg::QTY_BITS-1:0]    in_qty_r, in_qty_nxt;
  logic [plb_pkg::LVL_CW-1:0]      idx_r, idx_nxt;
  logic [plb_pkg::LVL_AW-1:0]      mv_r, mv_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [plb_pkg::ORD_AW-1:0]      clr_r, clr_nxt;
  logic [plb_pkg::LVL_CW-1:0]      bid_cnt_r, bid_cnt_nxt;
  logic [plb_pkg::LVL_CW-1:0]      ask_cnt_r, ask_cnt_nxt;
  plb_pkg::lvl_t                   top_bid_r, top_bid_nxt;
  plb_pkg::lvl_t                   top_ask_r, top_ask_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      o_status_r, o_status_nxt;
  logic                            o_bp_r, o_bp_nxt, o_ap_r, o_ap_nxt;
  plb_pkg::lvl_t                   o_bid_r, o_bid_nxt, o_ask_r, o_ask_nxt;
  logic [20:0]                     o_spread_r, o_spread_nxt;

  plb_pkg::ord_t                   ord_q_r, ord_wdata;
  logic                            ord_we, ord_rd;
  logic [plb_pkg::ORD_AW-1:0]      ord_waddr;
  plb_pkg::lvl_t                   lvl_q_r, lvl_wdata;
  logic                            lvl_we, lvl_rd;
  logic [plb_pkg::LVL_AW:0]        lvl_waddr, lvl_raddr;

  logic [plb_pkg::LVL_CW-1:0]      cnt_sel;
  logic                            better;
  logic [plb_pkg::TOT_BITS:0]      sum_w;
  logic [plb_pkg::TOT_BITS-1:0]    sat_sum;
  logic                            in_acc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign cnt_sel = side_r ? bid_cnt_r : ask_cnt_r;
  assign better  = side_r ? (lvl_q_r.price > price_r) : (lvl_q_r.price < price_r);
  assign sum_w   = {1'b0, lvl_q_r.qty} + (plb_pkg::TOT_BITS+1)'(qty_r);
  assign sat_sum = sum_w[plb_pkg::TOT_BITS] ? '1 : sum_w[plb_pkg::TOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_rd) begin
      ord_q_r <= ord_mem[slot_r[plb_pkg::ORD_AW-1:0]];
    end
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    if (lvl_rd) begin
      lvl_q_r <= lvl_mem[lvl_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    slot_nxt      = slot_r;
    side_nxt      = side_r;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    in_bid_nxt    = in_bid_r;
    in_price_nxt  = in_price_r;
    in_qty_nxt    = in_qty_r;
    idx_nxt       = idx_r;
    mv_nxt        = mv_r;
    status_nxt    = status_r;
    clr_nxt       = clr_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    top_bid_nxt   = top_bid_r;
    top_ask_nxt   = top_ask_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_bp_nxt      = o_bp_r;
    o_ap_nxt      = o_ap_r;
    o_bid_nxt     = o_bid_r;
    o_ask_nxt     = o_ask_r;
    o_spread_nxt  = o_spread_r;
    ord_we        = 1'b0;
    ord_rd        = 1'b0;
    ord_waddr     = slot_r[plb_pkg::ORD_AW-1:0];
    ord_wdata     = '0;
    lvl_we        = 1'b0;
    lvl_rd        = 1'b0;
    lvl_waddr     = {side_r, idx_r[plb_pkg::LVL_AW-1:0]};
    lvl_raddr     = {side_r, idx_r[plb_pkg::LVL_AW-1:0]};
    lvl_wdata     = lvl_q_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        ord_we    = 1'b1;
        ord_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == plb_pkg::ORD_AW'(plb_pkg::ORDER_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt      = in_if.action;
          slot_nxt     = in_if.slot_id;
          side_nxt     = in_if.is_bid;
          price_nxt    = in_if.price;
          qty_nxt      = in_if.quantity;
          in_bid_nxt   = in_if.is_bid;
          in_price_nxt = in_if.price;
          in_qty_nxt   = in_if.quantity;
          idx_nxt      = '0;
          status_nxt   = plb_pkg::ST_OK;
          case (in_if.action)
            plb_pkg::ACT_ADD: begin
              if (32'(in_if.slot_id) >= plb_pkg::ORDER_SLOTS) begin
                status_nxt = plb_pkg::ST_NOT_FOUND;
                state_nxt  = S_TOP_B;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            plb_pkg::ACT_CANCEL: begin
              if (32'(in_if.slot_id) >= plb_pkg::ORDER_SLOTS) begin
                status_nxt = plb_pkg::ST_NOT_FOUND;
                state_nxt  = S_TOP_B;
              end else begin
                state_nxt = S_ORD_WT;
              end
            end
            plb_pkg::ACT_REDUCE: state_nxt = S_SCAN_RD;
            default:             state_nxt = S_TOP_B;
          endcase
        end
      end
      S_ORD_WT: begin
        ord_rd    = 1'b1;
        state_nxt = S_ORD_CHK;
      end
      S_ORD_CHK: begin
        if (!ord_q_r.valid) begin
          status_nxt = plb_pkg::ST_NOT_FOUND;
          state_nxt  = S_TOP_B;
        end else begin
          // Release the slot, then take its quantity off its level.
          ord_we    = 1'b1;
          side_nxt  = ord_q_r.is_bid;
          price_nxt = ord_q_r.price;
          qty_nxt   = ord_q_r.qty;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_r == cnt_sel) begin
          // Ran off the end of the side without a match.
          if (act_r == plb_pkg::ACT_ADD) begin
            if (cnt_sel >= plb_pkg::LVL_CW'(plb_pkg::LEVEL_DEPTH)) begin
              status_nxt = plb_pkg::ST_FULL;
              state_nxt  = S_TOP_B;
            end else begin
              mv_nxt    = cnt_sel[plb_pkg::LVL_AW-1:0];
              state_nxt = S_INS_RD;
            end
          end else begin
            state_nxt = S_TOP_B;
          end
        end else begin
          lvl_rd    = 1'b1;
          state_nxt = S_SCAN_CM;
        end
      end
      S_SCAN_CM: begin
        if (lvl_q_r.price == price_r) begin
          if (act_r == plb_pkg::ACT_ADD) begin
            lvl_we    = 1'b1;
            lvl_wdata = '{price: price_r, qty: sat_sum};
            state_nxt = S_ADD_REC;
          end else if (lvl_q_r.qty > plb_pkg::TOT_BITS'(qty_r)) begin
            lvl_we    = 1'b1;
            lvl_wdata = '{price: price_r, qty: lvl_q_r.qty - plb_pkg::TOT_BITS'(qty_r)};
            state_nxt = S_TOP_B;
          end else begin
            state_nxt = S_DEL_RD;
          end
        end else if (better) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (act_r == plb_pkg::ACT_ADD) begin
          if (cnt_sel >= plb_pkg::LVL_CW'(plb_pkg::LEVEL_DEPTH)) begin
            status_nxt = plb_pkg::ST_FULL;
            state_nxt  = S_TOP_B;
          end else begin
            mv_nxt    = cnt_sel[plb_pkg::LVL_AW-1:0];
            state_nxt = S_INS_RD;
          end
        end else begin
          state_nxt = S_TOP_B;
        end
      end
      S_DEL_RD: begin
        if (idx_r + 1'b1 >= cnt_sel) begin
          if (side_r) begin
            bid_cnt_nxt = bid_cnt_r - 1'b1;
          end else begin
            ask_cnt_nxt = ask_cnt_r - 1'b1;
          end
          state_nxt = S_TOP_B;
        end else begin
          lvl_rd    = 1'b1;
          lvl_raddr = {side_r, idx_r[plb_pkg::LVL_AW-1:0] + 1'b1};
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        lvl_we    = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_INS_RD: begin
        if (mv_r == idx_r[plb_pkg::LVL_AW-1:0]) begin
          lvl_we    = 1'b1;
          lvl_wdata = '{price: price_r, qty: plb_pkg::TOT_BITS'(qty_r)};
          if (side_r) begin
            bid_cnt_nxt = bid_cnt_r + 1'b1;
          end else begin
            ask_cnt_nxt = ask_cnt_r + 1'b1;
          end
          state_nxt = S_ADD_REC;
        end else begin
          lvl_rd    = 1'b1;
          lvl_raddr = {side_r, mv_r - 1'b1};
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        lvl_we    = 1'b1;
        lvl_waddr = {side_r, mv_r};
        mv_nxt    = mv_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      S_ADD_REC: begin
        ord_we    = 1'b1;
        ord_wdata = '{valid: 1'b1, is_bid: in_bid_r, price: in_price_r, qty: in_qty_r};
        state_nxt = S_TOP_B;
      end
      S_TOP_B: begin
        lvl_rd    = 1'b1;
        lvl_raddr = {1'b1, {plb_pkg::LVL_AW{1'b0}}};
        state_nxt = S_TOP_A;
      end
      S_TOP_A: begin
        top_bid_nxt = lvl_q_r;
        lvl_rd      = 1'b1;
        lvl_raddr   = {1'b0, {plb_pkg::LVL_AW{1'b0}}};
        state_nxt   = S_TOP_L;
      end
      S_TOP_L: begin
        top_ask_nxt = lvl_q_r;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_bp_nxt      = bid_cnt_r != '0;
          o_ap_nxt      = ask_cnt_r != '0;
          o_bid_nxt     = (bid_cnt_r != '0) ? top_bid_r : '0;
          o_ask_nxt     = (ask_cnt_r != '0) ? top_ask_r : '0;
          o_spread_nxt  = (bid_cnt_r != '0 && ask_cnt_r != '0)
                        ? ({1'b0, top_ask_r.price} - {1'b0, top_bid_r.price}) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    slot_r     <= slot_nxt;
    side_r     <= side_nxt;
    price_r    <= price_nxt;
    qty_r      <= qty_nxt;
    in_bid_r   <= in_bid_nxt;
    in_price_r <= in_price_nxt;
    in_qty_r   <= in_qty_nxt;
    idx_r      <= idx_nxt;
    mv_r       <= mv_nxt;
    status_r   <= status_nxt;
    top_bid_r  <= top_bid_nxt;
    top_ask_r  <= top_ask_nxt;
    o_status_r <= o_status_nxt;
    o_bp_r     <= o_bp_nxt;
    o_ap_r     <= o_ap_nxt;
    o_bid_r    <= o_bid_nxt;
    o_ask_r    <= o_ask_nxt;
    o_spread_r <= o_spread_nxt;
  end

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.status         = o_status_r;
  assign out_if.bid_present    = o_bp_r;
  assign out_if.best_bid_price = o_bid_r.price;
  assign out_if.best_bid_qty   = o_bid_r.qty;
  assign out_if.ask_present    = o_ap_r;
  assign out_if.best_ask_price = o_ask_r.price;
  assign out_if.best_ask_qty   = o_ask_r.qty;
  assign out_if.spread_ticks   = $signed(o_spread_r);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt_r <= plb_pkg::LVL_CW'(plb_pkg::LEVEL_DEPTH) &&
    ask_cnt_r <= plb_pkg::LVL_CW'(plb_pkg::LEVEL_DEPTH))
    else $error("level count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer idle right after accepting a word");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLR |=> bid_cnt_r == $past(bid_cnt_r) ||
      bid_cnt_r == $past(bid_cnt_r) + 1'b1 || bid_cnt_r == $past(bid_cnt_r) - 1'b1)
    else $error("bid level count jumped");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output step");

endmodule

/* tb/sv/tb_price_level_order_book.sv */
// Testbench for the price level order book: directed and random book updates.
`timescale 1ns / 1ps

class plb_book_scoreboard;
  bit                    rec_valid[plb_pkg::ORDER_SLOTS];
  bit                    rec_bid[plb_pkg::ORDER_SLOTS];
  bit [19:0]             rec_price[plb_pkg::ORDER_SLOTS];
  bit [23:0]             rec_qty[plb_pkg::ORDER_SLOTS];
  bit [19:0]             lvl_price[2][$];
  bit [31:0]             lvl_qty[2][$];
  bit [148:0]            pending_tops[$];
  int                    errors;

  function int find_level(int s, bit [19:0] p);
    for (int i = 0; i < lvl_price[s].size(); i++)
      if (lvl_price[s][i] == p) return i;
    return -1;
  endfunction

  function bit add_level(bit bid, bit [19:0] p, bit [23:0] q);
    int s;
    int i;
    int pos;
    bit [32:0] sum;
    s = bid;
    i = find_level(s, p);
    if (i >= 0) begin
      sum = lvl_qty[s][i] + q;
      lvl_qty[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      return 1;
    end
    if (lvl_price[s].size() >= plb_pkg::LEVEL_DEPTH) return 0;
    pos = 0;
    while (pos < lvl_price[s].size() &&
           (bid ? lvl_price[s][pos] > p : lvl_price[s][pos] < p)) pos++;
    lvl_price[s].insert(pos, p);
    lvl_qty[s].insert(pos, {8'd0, q});
    return 1;
  endfunction

  function void reduce_level(bit bid, bit [19:0] p, bit [31:0] q);
    int s;
    int i;
    s = bid;
    i = find_level(s, p);
    if (i < 0) return;
    if (lvl_qty[s][i] > q) lvl_qty[s][i] -= q;
    else begin
      lvl_price[s].delete(i);
      lvl_qty[s].delete(i);
    end
  endfunction

  function int level_count(bit bid);
    return lvl_price[bid].size();
  endfunction

  // Applies one word to the book and queues the expected top of book.
  function void note_word(bit [1:0] act, bit [9:0] id, bit [19:0] p, bit [23:0] q, bit bid);
    bit [1:0]  st;
    bit        bp;
    bit        ap;
    bit [19:0] bbp;
    bit [19:0] bap;
    bit [31:0] bbq;
    bit [31:0] baq;
    bit [20:0] spr;
    st = plb_pkg::ST_OK;
    bbp = 0; bap = 0; bbq = 0; baq = 0; spr = 0;
    if (act == plb_pkg::ACT_ADD) begin
      if (!add_level(bid, p, q)) st = plb_pkg::ST_FULL;
      else begin
        rec_valid[id] = 1; rec_bid[id] = bid; rec_price[id] = p; rec_qty[id] = q;
      end
    end else if (act == plb_pkg::ACT_CANCEL) begin
      if (!rec_valid[id]) st = plb_pkg::ST_NOT_FOUND;
      else begin
        reduce_level(rec_bid[id], rec_price[id], {8'd0, rec_qty[id]});
        rec_valid[id] = 0;
      end
    end else if (act == plb_pkg::ACT_REDUCE) begin
      reduce_level(bid, p, {8'd0, q});
    end
    bp = lvl_price[1].size() > 0;
    ap = lvl_price[0].size() > 0;
    if (bp) begin bbp = lvl_price[1][0]; bbq = lvl_qty[1][0]; end
    if (ap) begin bap = lvl_price[0][0]; baq = lvl_qty[0][0]; end
    if (bp && ap) spr = {1'b0, bap} - {1'b0, bbp};
    pending_tops.push_back({st, bp, bbp, bbq, ap, bap, baq, 20'd0, spr});
  endfunction

  function void check_tops(bit [148:0] got);
    bit [148:0] exp;
    if (pending_tops.size() == 0) begin
      $error("result word with no expectation: %h", got);
      errors++;
      return;
    end
    exp = pending_tops.pop_front();
    if (exp[148:147] !== got[148:147]) begin
      $error("status exp %0d got %0d", exp[148:147], got[148:147]); errors++; end
    if (exp[146] !== got[146]) begin
      $error("bid_present exp %0d got %0d", exp[146], got[146]); errors++; end
    if (exp[145:126] !== got[145:126]) begin
      $error("best_bid_price exp %0d got %0d", exp[145:126], got[145:126]); errors++; end
    if (exp[125:94] !== got[125:94]) begin
      $error("best_bid_qty exp %0d got %0d", exp[125:94], got[125:94]); errors++; end
    if (exp[93] !== got[93]) begin
      $error("ask_present exp %0d got %0d", exp[93], got[93]); errors++; end
    if (exp[92:73] !== got[92:73]) begin
      $error("best_ask_price exp %0d got %0d", exp[92:73], got[92:73]); errors++; end
    if (exp[72:41] !== got[72:41]) begin
      $error("best_ask_qty exp %0d got %0d", exp[72:41], got[72:41]); errors++; end
    if (exp[20:0] !== got[20:0]) begin
      $error("spread_ticks exp %0d got %0d", $signed(exp[20:0]), $signed(got[20:0]));
      errors++;
    end
  endfunction
endclass

module tb_price_level_order_book;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  plb_in_if  in_ch();
  plb_out_if out_ch();

  plb_book_scoreboard book;
  bit  quiet_tail;
  bit  hold_sink;
  int  idle_cycles = 0;

  price_level_order_book u_dut (.clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Sink side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      book.check_tops({out_ch.status, out_ch.bid_present, out_ch.best_bid_price,
                       out_ch.best_bid_qty, out_ch.ask_present, out_ch.best_ask_price,
                       out_ch.best_ask_qty, 20'd0, out_ch.spread_ticks});
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Valid stays high after an accept; the next word or an idle gap replaces it.
  task automatic send_word(bit [1:0] act, bit [9:0] id, bit [19:0] p, bit [23:0] q, bit bid);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid    <= 1;
    in_ch.action   <= act;
    in_ch.slot_id  <= id;
    in_ch.price    <= p;
    in_ch.quantity <= q;
    in_ch.is_bid   <= bid;
    do @(posedge clk); while (!in_ch.ready);
    book.note_word(act, id, p, q, bid);
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    do @(posedge clk); while (book.pending_tops.size() != 0);
  endtask

  // Mostly well-formed traffic around a mid price, with some noise.
  task automatic send_random_word();
    int        r;
    bit [9:0]  id;
    bit [19:0] p;
    bit [23:0] q;
    bit        bid;
    r = $urandom_range(0, 99);
    id = 10'($urandom_range(0, 127));
    bid = 1'($urandom_range(0, 1));
    p = bid ? 20'(5000 - $urandom_range(0, 40)) : 20'(5001 + $urandom_range(0, 40));
    q = 24'($urandom_range(1, 5000));
    if (r < 5) begin
      id = 10'($urandom);
      p = 20'($urandom);
      q = 24'($urandom);
    end
    if (r < 50) send_word(plb_pkg::ACT_ADD, id, p, q, bid);
    else if (r < 80) send_word(plb_pkg::ACT_CANCEL, id, p, q, bid);
    else if (r < 97) send_word(plb_pkg::ACT_REDUCE, id, p, q, bid);
    else send_word(plb_pkg::ACT_NONE, id, p, q, bid);
  endtask

  initial begin
    book = new();
    quiet_tail = 0;
    hold_sink = 0;
    in_ch.valid <= 0;
    in_ch.action <= plb_pkg::ACT_ADD;
    in_ch.slot_id <= 0;
    in_ch.price <= 0;
    in_ch.quantity <= 0;
    in_ch.is_bid <= 0;
    rst_n <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every action and the special cases.
    send_word(plb_pkg::ACT_CANCEL, 10'd0, '0, '0, 1'b0);
    send_word(plb_pkg::ACT_ADD, 10'd0, 20'hFFFFF, 24'hFFFFFF, 1);
    send_word(plb_pkg::ACT_ADD, 10'd1023, 20'd0, 24'hFFFFFF, 0);
    send_word(plb_pkg::ACT_ADD, 10'd5, 20'd100, 24'd0, 0);
    send_word(plb_pkg::ACT_REDUCE, 10'd0, 20'd100, 24'd0, 0);
    send_word(plb_pkg::ACT_ADD, 10'd0, 20'hFFFFF, 24'd7, 1);
    send_word(plb_pkg::ACT_CANCEL, 10'd0, '0, '0, 1'b0);
    send_word(plb_pkg::ACT_CANCEL, 10'd0, '0, '0, 1'b0);
    send_word(plb_pkg::ACT_REDUCE, 10'd0, 20'd12345, 24'd1, 1);
    send_word(plb_pkg::ACT_NONE, 10'h3FF, 20'hFFFFF, 24'hFFFFFF, 1);
    for (int k = 0; k < 300; k++)
      send_word(plb_pkg::ACT_ADD, 10'd2, 20'd77, 24'hFFFFFF, 1);
    send_word(plb_pkg::ACT_REDUCE, 10'd0, 20'd77, 24'hFFFFFF, 1);
    send_word(plb_pkg::ACT_CANCEL, 10'd2, '0, '0, 1'b0);
    send_word(plb_pkg::ACT_REDUCE, 10'd0, 20'hFFFFF, 24'hFFFFFF, 1);
    send_word(plb_pkg::ACT_REDUCE, 10'd0, 20'd0, 24'hFFFFFF, 0);
    // Fill the ask side, then one more price is refused.
    for (int k = 0; k <= plb_pkg::LEVEL_DEPTH; k++)
      send_word(plb_pkg::ACT_ADD, 10'(600 + k), 20'(900000 - 3 * k), 24'(k + 1), 0);
    send_word(plb_pkg::ACT_ADD, 10'd600, 20'd900000, 24'd5, 0);
    for (int k = 0; k <= plb_pkg::LEVEL_DEPTH; k++)
      send_word(plb_pkg::ACT_CANCEL, 10'(600 + k), '0, '0, 1'b0);

    // Long receiver hold-off while words keep coming.
    hold_sink = 1;
    for (int n = 0; n < 20; n++) send_random_word();
    drain_results();
    repeat (300) @(posedge clk);

    for (int n = 0; n < 1550; n++) begin
      if (n == 1300) quiet_tail = 1;
      if (n == 800) drain_results();
      send_random_word();
    end
    drain_results();
    repeat (300) @(posedge clk);
    if (book.errors == 0 && book.pending_tops.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
